>>> src/pttc_pkg.sv
package pttc_pkg;

    // Event codes carried on the kind field
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_SET    = 3'd1;
    localparam logic [2:0] KIND_HOME   = 3'd2;
    localparam logic [2:0] KIND_TRACK  = 3'd3;
    localparam logic [2:0] KIND_VISION = 3'd4;
    localparam logic [2:0] KIND_STOP   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_CENTER_X   = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y   = 2'd1;
    localparam logic [1:0] CFG_TRACK_GAIN = 2'd2;

    localparam logic [9:0] CENTER_X_RESET   = 10'd320;
    localparam logic [9:0] CENTER_Y_RESET   = 10'd240;
    localparam logic [5:0] TRACK_GAIN_RESET = 6'd10;

    // Angle limits, hundredths of a degree
    localparam logic signed [18:0] PAN_LO  = -19'sd18000;
    localparam logic signed [18:0] PAN_HI  = 19'sd18000;
    localparam logic signed [18:0] TILT_LO = -19'sd4500;
    localparam logic signed [18:0] TILT_HI = 19'sd9000;

    // Reset slew rates 3000 and 2000, kept as per-tick steps (rate / 100)
    localparam logic [9:0] PAN_STEP_RESET  = 10'd30;
    localparam logic [9:0] TILT_STEP_RESET = 10'd20;

    localparam logic [10:0] PULSE_MIN = 11'd1000;
    localparam logic [10:0] PULSE_MAX = 11'd2000;

    typedef enum logic [1:0] {
        MODE_IDLE        = 2'd0,
        MODE_HOMING      = 2'd1,
        MODE_POSITIONING = 2'd2,
        MODE_TRACKING    = 2'd3
    } t_mode;

    // rate / 100 via reciprocal 83887 / 2^23, exact for every 16-bit rate
    function automatic logic [9:0] f_rate_to_step(input logic [15:0] rate);
        logic [32:0] prod;
        prod = {17'd0, rate} * 33'd83887;
        return prod[32:23];
    endfunction

    function automatic logic signed [15:0] f_clamp(input logic signed [18:0] v,
                                                   input logic signed [18:0] lo,
                                                   input logic signed [18:0] hi);
        logic signed [18:0] c;
        if (v < lo) begin
            c = lo;
        end else if (v > hi) begin
            c = hi;
        end else begin
            c = v;
        end
        return c[15:0];
    endfunction

    // Move toward goal by step, no overshoot
    function automatic logic signed [15:0] f_approach(input logic signed [15:0] now,
                                                      input logic signed [15:0] goal,
                                                      input logic [9:0] step);
        logic signed [16:0] up;
        logic signed [16:0] dn;
        logic signed [16:0] g;
        logic signed [15:0] r;
        up = $signed({now[15], now}) + $signed({7'd0, step});
        dn = $signed({now[15], now}) - $signed({7'd0, step});
        g  = $signed({goal[15], goal});
        if (now < goal) begin
            r = (up > g) ? goal : up[15:0];
        end else if (now > goal) begin
            r = (dn < g) ? goal : dn[15:0];
        end else begin
            r = now;
        end
        return r;
    endfunction

endpackage

>>> src/pan_tilt_turret_controller_unit.sv
// Pan/tilt turret controller.
// Input channel (i_in_valid / o_in_ready) carries one event per transaction:
// tick, set position, home, track, vision target or emergency stop. Every
// event yields exactly one result transaction on the output channel
// (o_out_valid / i_out_ready): servo pulse widths, mode, status flags and the
// current pan and tilt angles in hundredths of a degree.
// The event is evaluated by combinational logic from the state registers and
// lands in the result register at the accepting edge.
// Throughput is one event per cycle; the single result register sets that
// figure, and o_in_ready stays high while the result is taken in the same
// cycle. When the receiver stalls, the result holds and o_in_ready drops
// until the result is taken.
// Configuration (image centre, tracking gain) is written through
// i_cfg_we / i_cfg_index / i_cfg_data, one register per cycle, no wait.
// Reset (i_rst_n low, synchronous) returns to idle with both angles and
// setpoints at zero, slew rates 3000 and 2000, flags cleared, the result
// register empty and the configuration at its defaults.
module pan_tilt_turret_controller_unit
    import pttc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_pan_command,
    input  logic signed [15:0] i_tilt_command,
    input  logic [15:0]        i_slew_request,
    input  logic [9:0]         i_pixel_x,
    input  logic [9:0]         i_pixel_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [10:0]        o_pan_pulse,
    output logic [10:0]        o_tilt_pulse,
    output logic               o_pulse_update,
    output logic [1:0]         o_mode,
    output logic               o_enabled_flag,
    output logic               o_tracking_flag,
    output logic               o_homed_flag,
    output logic signed [15:0] o_pan_position,
    output logic signed [14:0] o_tilt_position
);

    // Configuration registers
    logic [9:0] r_center_x;
    logic [9:0] r_center_y;
    logic [5:0] r_track_gain;

    // Controller state
    t_mode             r_mode,        n_mode;
    logic signed [15:0] r_pan_target,  n_pan_target;
    logic signed [15:0] r_tilt_target, n_tilt_target;
    logic signed [15:0] r_pan_now,     n_pan_now;
    logic signed [15:0] r_tilt_now,    n_tilt_now;
    logic [9:0]         r_pan_step,    n_pan_step;
    logic [9:0]         r_tilt_step,   n_tilt_step;
    logic               r_enabled,     n_enabled;
    logic               r_tracking,    n_tracking;
    logic               r_homed,       n_homed;
    logic               n_update;

    // Result register
    logic               r_out_valid;
    logic               r_out_update;
    t_mode              r_out_mode;
    logic               r_out_enabled;
    logic               r_out_tracking;
    logic               r_out_homed;
    logic signed [15:0] r_out_pan;
    logic signed [14:0] r_out_tilt;

    logic in_accept;

    // Next angles on a tick
    logic signed [15:0] pan_appr;
    logic signed [15:0] tilt_appr;

    // Tracking setpoints
    logic signed [11:0] err_x;
    logic signed [11:0] err_y;
    logic signed [18:0] prod_x;
    logic signed [18:0] prod_y;
    logic signed [18:0] sum_x;
    logic signed [18:0] sum_y;

    // Pulse conversion
    logic signed [16:0] pan_off;
    logic [28:0]        pan_prod;
    logic signed [15:0] tilt_off;
    logic [30:0]        tilt_prod;

    // Accept a new event while the result slot is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    assign pan_appr  = f_approach(r_pan_now, r_pan_target, r_pan_step);
    assign tilt_appr = f_approach(r_tilt_now, r_tilt_target, r_tilt_step);

    // Pixel error times gain, added to the actual angle wide, clamped later
    assign err_x  = $signed({2'd0, r_center_x}) - $signed({2'd0, i_pixel_x});
    assign err_y  = $signed({2'd0, r_center_y}) - $signed({2'd0, i_pixel_y});
    assign prod_x = err_x * $signed({1'b0, r_track_gain});
    assign prod_y = err_y * $signed({1'b0, r_track_gain});
    assign sum_x  = prod_x + $signed({{3{r_pan_now[15]}}, r_pan_now});
    assign sum_y  = prod_y + $signed({{3{r_tilt_now[15]}}, r_tilt_now});

    // Mode sequencing
    always_comb begin
        n_mode = r_mode;
        if (in_accept) begin
            unique case (i_kind)
                KIND_TICK: begin
                    if (r_mode == MODE_HOMING && pan_appr == 16'sd0 && tilt_appr == 16'sd0) begin
                        n_mode = MODE_IDLE;
                    end
                end
                KIND_SET: begin
                    if (r_mode == MODE_IDLE) begin
                        n_mode = MODE_POSITIONING;
                    end
                end
                KIND_HOME: begin
                    if (r_mode != MODE_HOMING) begin
                        n_mode = MODE_HOMING;
                    end
                end
                KIND_TRACK: begin
                    if (r_mode == MODE_IDLE || r_mode == MODE_POSITIONING) begin
                        n_mode = MODE_TRACKING;
                    end
                end
                KIND_STOP: begin
                    if (r_mode != MODE_IDLE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Setpoints, angles, rates and flags
    always_comb begin
        n_pan_target  = r_pan_target;
        n_tilt_target = r_tilt_target;
        n_pan_now     = r_pan_now;
        n_tilt_now    = r_tilt_now;
        n_pan_step    = r_pan_step;
        n_tilt_step   = r_tilt_step;
        n_homed       = r_homed;
        n_update      = 1'b0;
        if (in_accept) begin
            unique case (i_kind)
                KIND_TICK: begin
                    if (r_mode != MODE_IDLE) begin
                        n_pan_now  = pan_appr;
                        n_tilt_now = tilt_appr;
                        n_update   = 1'b1;
                        if (r_mode == MODE_HOMING && pan_appr == 16'sd0
                            && tilt_appr == 16'sd0) begin
                            n_homed = 1'b1;
                        end
                    end
                end
                KIND_SET: begin
                    if (r_mode == MODE_IDLE || r_mode == MODE_POSITIONING) begin
                        n_pan_target  = f_clamp($signed({{3{i_pan_command[15]}}, i_pan_command}),
                                                PAN_LO, PAN_HI);
                        n_tilt_target = f_clamp($signed({{3{i_tilt_command[15]}},
                                                i_tilt_command}), TILT_LO, TILT_HI);
                        // Take a new rate only when leaving idle, zero keeps the old one
                        if (r_mode == MODE_IDLE && i_slew_request != 16'd0) begin
                            n_pan_step  = f_rate_to_step(i_slew_request);
                            n_tilt_step = f_rate_to_step(i_slew_request);
                        end
                    end
                end
                KIND_VISION: begin
                    if (r_mode == MODE_TRACKING) begin
                        n_pan_target  = f_clamp(sum_x, PAN_LO, PAN_HI);
                        n_tilt_target = f_clamp(sum_y, TILT_LO, TILT_HI);
                    end
                end
                default: begin
                end
            endcase
        end
        // Entering homing drives both setpoints to zero
        if (n_mode == MODE_HOMING && r_mode != MODE_HOMING) begin
            n_pan_target  = 16'sd0;
            n_tilt_target = 16'sd0;
        end
    end

    // Flags follow mode entry; every mode change is an entry
    always_comb begin
        n_enabled  = r_enabled;
        n_tracking = r_tracking;
        if (n_mode != r_mode) begin
            n_enabled = (n_mode != MODE_IDLE);
            if (n_mode == MODE_POSITIONING) begin
                n_tracking = 1'b0;
            end else if (n_mode == MODE_TRACKING) begin
                n_tracking = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= CENTER_X_RESET;
            r_center_y   <= CENTER_Y_RESET;
            r_track_gain <= TRACK_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:   r_center_x   <= i_cfg_data;
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data;
                CFG_TRACK_GAIN: r_track_gain <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_pan_target  <= 16'sd0;
            r_tilt_target <= 16'sd0;
            r_pan_now     <= 16'sd0;
            r_tilt_now    <= 16'sd0;
            r_pan_step    <= PAN_STEP_RESET;
            r_tilt_step   <= TILT_STEP_RESET;
            r_enabled     <= 1'b0;
            r_tracking    <= 1'b0;
            r_homed       <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_pan_target  <= n_pan_target;
            r_tilt_target <= n_tilt_target;
            r_pan_now     <= n_pan_now;
            r_tilt_now    <= n_tilt_now;
            r_pan_step    <= n_pan_step;
            r_tilt_step   <= n_tilt_step;
            r_enabled     <= n_enabled;
            r_tracking    <= n_tracking;
            r_homed       <= n_homed;
        end
    end

    // Result slot: fill on accept, empty when taken and nothing new arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_update   <= n_update;
            r_out_mode     <= n_mode;
            r_out_enabled  <= n_enabled;
            r_out_tracking <= n_tracking;
            r_out_homed    <= n_homed;
            r_out_pan      <= n_pan_now;
            r_out_tilt     <= n_tilt_now[14:0];
        end
    end

    // Pulse widths from the registered angles (angles always stay in range)
    // pan: 1000 + n/36 with n/36 = (n/4) * 14564 / 2^17
    assign pan_off  = $signed({r_out_pan[15], r_out_pan}) + 17'sd18000;
    assign pan_prod = {15'd0, pan_off[15:2]} * 29'd14564;
    // tilt: 1000 + 2n/27 with 2n * 38837 / 2^20
    assign tilt_off  = $signed({r_out_tilt[14], r_out_tilt}) + 16'sd4500;
    assign tilt_prod = {16'd0, tilt_off[13:0], 1'b0} * 31'd38837;

    assign o_pan_pulse     = PULSE_MIN + {1'b0, pan_prod[26:17]};
    assign o_tilt_pulse    = PULSE_MIN + {1'b0, tilt_prod[29:20]};
    assign o_out_valid     = r_out_valid;
    assign o_pulse_update  = r_out_update;
    assign o_mode          = r_out_mode;
    assign o_enabled_flag  = r_out_enabled;
    assign o_tracking_flag = r_out_tracking;
    assign o_homed_flag    = r_out_homed;
    assign o_pan_position  = r_out_pan;
    assign o_tilt_position = r_out_tilt;

endmodule

>>> src/pttc_checker.sv
module pttc_checker
    import pttc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [10:0]        o_pan_pulse,
    input logic [10:0]        o_tilt_pulse,
    input logic               o_pulse_update,
    input logic [1:0]         o_mode,
    input logic               o_enabled_flag,
    input logic               o_homed_flag,
    input logic signed [15:0] o_pan_position,
    input logic signed [14:0] o_tilt_position
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pan_position)
            && $stable(o_tilt_position) && $stable(o_mode))
        else $error("result changed while stalled");

    // An empty result slot never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result slot");

    // Drive is enabled exactly outside idle
    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_enabled_flag == (o_mode != MODE_IDLE)))
        else $error("enabled flag disagrees with mode");

    // A moving tick that ends in idle is homing completion
    a_home_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pulse_update && o_mode == MODE_IDLE |->
            o_homed_flag && o_pan_position == 16'sd0 && o_tilt_position == 15'sd0)
        else $error("tick into idle without homing at zero");

    // Pulses stay within the servo range
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pan_pulse >= PULSE_MIN && o_pan_pulse <= PULSE_MAX
            && o_tilt_pulse >= PULSE_MIN && o_tilt_pulse <= PULSE_MAX)
        else $error("pulse width out of range");

endmodule

bind pan_tilt_turret_controller_unit pttc_checker u_pttc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pan_pulse     (o_pan_pulse),
    .o_tilt_pulse    (o_tilt_pulse),
    .o_pulse_update  (o_pulse_update),
    .o_mode          (o_mode),
    .o_enabled_flag  (o_enabled_flag),
    .o_homed_flag    (o_homed_flag),
    .o_pan_position  (o_pan_position),
    .o_tilt_position (o_tilt_position)
);
